>>> rtl/core/ccb_pkg.sv
`timescale 1ns / 1ps
// ccb_pkg: types, constants and helper functions for the ChaCha20 keystream core.
// No dependencies; used by ccb_cell, ccb_out and chacha20_block_keystream_top.
package ccb_pkg;

    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [15:0][WORD_W-1:0] state_t;
    typedef logic [7:0][63:0] ks_t;
    typedef logic [3:0][63:0] key_t;

    typedef struct packed {
        logic diag;
        logic second;
    } cell_mode_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } qr_t;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;

    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    // half a quarter round: rotations 16/12 in the first half, 8/7 in the second
    function automatic qr_t qr_half(input qr_t q, input logic second);
        qr_t   r;
        word_t x;
        r = q;
        r.a = q.a + q.b;
        x = q.d ^ r.a;
        r.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
        r.c = q.c + r.d;
        x = q.b ^ r.c;
        r.b = second ? {x[24:0], x[31:25]} : {x[19:0], x[31:20]};
        return r;
    endfunction

    // state word used by a lane in a given row; diagonal rounds shift row r by r
    function automatic logic [3:0] lane_idx(input logic [1:0] row, input logic [1:0] lane,
                                            input logic diag);
        logic [1:0] col;
        col = lane + (diag ? row : 2'd0);
        return {row, col};
    endfunction

    function automatic state_t build_state(input key_t key, input logic [63:0] nonce_low,
                                           input word_t nonce_high, input word_t ctr);
        state_t s;
        s[0]  = SIGMA0;
        s[1]  = SIGMA1;
        s[2]  = SIGMA2;
        s[3]  = SIGMA3;
        s[4]  = key[0][31:0];
        s[5]  = key[0][63:32];
        s[6]  = key[1][31:0];
        s[7]  = key[1][63:32];
        s[8]  = key[2][31:0];
        s[9]  = key[2][63:32];
        s[10] = key[3][31:0];
        s[11] = key[3][63:32];
        s[12] = ctr;
        s[13] = nonce_low[31:0];
        s[14] = nonce_low[63:32];
        s[15] = nonce_high;
        return s;
    endfunction

endpackage

>>> rtl/core/ccb_cell.sv
`timescale 1ns / 1ps
// ccb_cell: one link of the round chain, four parallel half quarter rounds.
// Depends on ccb_pkg.
module ccb_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  ccb_pkg::cell_mode_t mode,
    input  logic                in_valid,
    input  ccb_pkg::state_t     in_state,
    input  ccb_pkg::word_t      in_ctr,
    output logic                out_valid,
    output ccb_pkg::state_t     out_state,
    output ccb_pkg::word_t      out_ctr
);

    logic            valid_reg;
    ccb_pkg::state_t state_reg;
    ccb_pkg::state_t state_next;
    ccb_pkg::word_t  ctr_reg;

    always_comb begin
        ccb_pkg::qr_t q;
        logic [3:0]   ia;
        logic [3:0]   ib;
        logic [3:0]   ic;
        logic [3:0]   id;
        state_next = in_state;
        for (int j = 0; j < 4; j++) begin
            ia = ccb_pkg::lane_idx(2'd0, 2'(j), mode.diag);
            ib = ccb_pkg::lane_idx(2'd1, 2'(j), mode.diag);
            ic = ccb_pkg::lane_idx(2'd2, 2'(j), mode.diag);
            id = ccb_pkg::lane_idx(2'd3, 2'(j), mode.diag);
            q = ccb_pkg::qr_half({in_state[ia], in_state[ib], in_state[ic], in_state[id]},
                                 mode.second);
            state_next[ia] = q.a;
            state_next[ib] = q.b;
            state_next[ic] = q.c;
            state_next[id] = q.d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
            ctr_reg   <= in_ctr;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_ctr   = ctr_reg;

endmodule

>>> rtl/core/ccb_out.sv
`timescale 1ns / 1ps
// ccb_out: feed-forward add of the starting state and little-endian packing
// into the result register. Depends on ccb_pkg.
module ccb_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  ccb_pkg::state_t in_state,
    input  ccb_pkg::word_t  in_ctr,
    input  ccb_pkg::key_t   key,
    input  logic [63:0]     nonce_low,
    input  ccb_pkg::word_t  nonce_high,
    output logic            out_valid,
    output ccb_pkg::ks_t    out_ks
);

    logic            valid_reg;
    ccb_pkg::ks_t    ks_reg;
    ccb_pkg::ks_t    ks_next;
    ccb_pkg::state_t init;
    ccb_pkg::state_t sum;

    assign init = ccb_pkg::build_state(key, nonce_low, nonce_high, in_ctr);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sum[i] = in_state[i] + init[i];
        end
        for (int k = 0; k < 8; k++) begin
            ks_next[k] = {sum[2*k+1], sum[2*k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ks_reg <= ks_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ks    = ks_reg;

endmodule

>>> rtl/core/chacha20_block_keystream_top.sv
`timescale 1ns / 1ps
// chacha20_block_keystream_top: ChaCha20 block function, one 64-byte keystream block per beat.
// Each input beat passes through the half-quarter-round cell chain, then the result register.
// Throughput: one block per cycle unless stalled, set by the chain of half-quarter-round cells,
// each a registered step; the whole chain and result register stall together.
// Reset (aresetn, synchronous, active low) empties the chain and zeroes key and nonce.
// Depends on ccb_pkg, ccb_cell and ccb_out.
module chacha20_block_keystream_top #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ccb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [31:0]                      s_block_counter,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [63:0]                      m_keystream_0,
    output logic [63:0]                      m_keystream_1,
    output logic [63:0]                      m_keystream_2,
    output logic [63:0]                      m_keystream_3,
    output logic [63:0]                      m_keystream_4,
    output logic [63:0]                      m_keystream_5,
    output logic [63:0]                      m_keystream_6,
    output logic [63:0]                      m_keystream_7
);

    localparam int NUM_CELLS = 4 * DOUBLE_ROUNDS;

    ccb_pkg::key_t   key_reg;
    logic [63:0]     nonce_low_reg;
    ccb_pkg::word_t  nonce_high_reg;

    logic            pipe_en;
    logic [NUM_CELLS:0] chain_valid;
    ccb_pkg::state_t chain_state [NUM_CELLS+1];
    ccb_pkg::word_t  chain_ctr   [NUM_CELLS+1];
    ccb_pkg::ks_t    ks;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg        <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ccb_pkg::REG_KEY_PART0:  key_reg[0]     <= cfg_data;
                ccb_pkg::REG_KEY_PART1:  key_reg[1]     <= cfg_data;
                ccb_pkg::REG_KEY_PART2:  key_reg[2]     <= cfg_data;
                ccb_pkg::REG_KEY_PART3:  key_reg[3]     <= cfg_data;
                ccb_pkg::REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                ccb_pkg::REG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    assign chain_valid[0] = s_valid;
    assign chain_state[0] = ccb_pkg::build_state(key_reg, nonce_low_reg, nonce_high_reg,
                                                 s_block_counter);
    assign chain_ctr[0]   = s_block_counter;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        ccb_pkg::cell_mode_t mode;
        assign mode.second = ((k % 2) == 1);
        assign mode.diag   = (((k / 2) % 2) == 1);

        ccb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .mode      (mode),
            .in_valid  (chain_valid[k]),
            .in_state  (chain_state[k]),
            .in_ctr    (chain_ctr[k]),
            .out_valid (chain_valid[k+1]),
            .out_state (chain_state[k+1]),
            .out_ctr   (chain_ctr[k+1])
        );
    end

    ccb_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (chain_valid[NUM_CELLS]),
        .in_state   (chain_state[NUM_CELLS]),
        .in_ctr     (chain_ctr[NUM_CELLS]),
        .key        (key_reg),
        .nonce_low  (nonce_low_reg),
        .nonce_high (nonce_high_reg),
        .out_valid  (m_valid),
        .out_ks     (ks)
    );

    assign m_keystream_0 = ks[0];
    assign m_keystream_1 = ks[1];
    assign m_keystream_2 = ks[2];
    assign m_keystream_3 = ks[3];
    assign m_keystream_4 = ks[4];
    assign m_keystream_5 = ks[5];
    assign m_keystream_6 = ks[6];
    assign m_keystream_7 = ks[7];

`ifndef NO_ASSERTIONS
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid straight after reset");

    a_stall_holds_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(chain_valid[NUM_CELLS:1]))
        else $error("round chain moved while stalled");

    a_result_from_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(chain_valid[NUM_CELLS]))
        else $error("result beat appeared without a block at the chain end");
`endif

endmodule

>>> verif/chacha20_block_keystream_top_tb.sv
`timescale 1ns / 1ps
// chacha20_block_keystream_top_tb: self-checking bench for the ChaCha20 keystream block.
// A queue-fed driver, a monitor and a scoreboard against a bench-side block function.
// Depends on ccb_pkg and chacha20_block_keystream_top.
module chacha20_block_keystream_top_tb;

    localparam int DOUBLE_ROUNDS  = 10;
    localparam int LATENCY        = 4 * DOUBLE_ROUNDS + 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_WAIT       = 12;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 233;
    localparam int MAX_REPORTS    = 10;

    localparam logic [ccb_pkg::CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [ccb_pkg::CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    logic                           aclk            = 1'b0;
    logic                           aresetn         = 1'b0;
    logic                           cfg_wr_en       = 1'b0;
    logic [ccb_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [ccb_pkg::CFG_DATA_W-1:0] cfg_data        = '0;
    logic                           s_valid         = 1'b0;
    logic                           s_ready;
    logic [31:0]                    s_block_counter = '0;
    logic                           m_valid;
    logic                           m_ready         = 1'b0;
    logic [63:0]                    m_keystream_0;
    logic [63:0]                    m_keystream_1;
    logic [63:0]                    m_keystream_2;
    logic [63:0]                    m_keystream_3;
    logic [63:0]                    m_keystream_4;
    logic [63:0]                    m_keystream_5;
    logic [63:0]                    m_keystream_6;
    logic [63:0]                    m_keystream_7;

    // bench copy of the register file
    ccb_pkg::key_t  key_q      = '0;
    logic [63:0]    nonce_lo_q = '0;
    ccb_pkg::word_t nonce_hi_q = '0;

    logic [31:0]   counter_pending[$];
    ccb_pkg::ks_t  ks_expected[$];

    int fail_cnt     = 0;
    int stall_cycles = 0;
    int s_wait_left  = 0;
    int s_calm_left  = 0;
    bit s_calm       = 1'b0;
    int m_wait_left  = 0;
    int m_calm_left  = 0;
    bit m_calm       = 1'b0;
    ccb_pkg::ks_t ks_got;
    ccb_pkg::ks_t ks_want;

    chacha20_block_keystream_top #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_block_counter(s_block_counter),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_keystream_0  (m_keystream_0),
        .m_keystream_1  (m_keystream_1),
        .m_keystream_2  (m_keystream_2),
        .m_keystream_3  (m_keystream_3),
        .m_keystream_4  (m_keystream_4),
        .m_keystream_5  (m_keystream_5),
        .m_keystream_6  (m_keystream_6),
        .m_keystream_7  (m_keystream_7)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic ccb_pkg::word_t rotl(input ccb_pkg::word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic ccb_pkg::state_t quarter_round(input ccb_pkg::state_t s, input int a,
                                                      input int b, input int c, input int d);
        s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 7);
        return s;
    endfunction

    function automatic ccb_pkg::ks_t predict_keystream(input ccb_pkg::word_t ctr);
        ccb_pkg::state_t init;
        ccb_pkg::state_t x;
        ccb_pkg::ks_t    ks;
        init[0] = ccb_pkg::SIGMA0;
        init[1] = ccb_pkg::SIGMA1;
        init[2] = ccb_pkg::SIGMA2;
        init[3] = ccb_pkg::SIGMA3;
        for (int k = 0; k < 4; k++) begin
            init[4 + 2 * k] = key_q[k][31:0];
            init[5 + 2 * k] = key_q[k][63:32];
        end
        init[12] = ctr;
        init[13] = nonce_lo_q[31:0];
        init[14] = nonce_lo_q[63:32];
        init[15] = nonce_hi_q;
        x = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            x = quarter_round(x, 0, 4, 8, 12);
            x = quarter_round(x, 1, 5, 9, 13);
            x = quarter_round(x, 2, 6, 10, 14);
            x = quarter_round(x, 3, 7, 11, 15);
            x = quarter_round(x, 0, 5, 10, 15);
            x = quarter_round(x, 1, 6, 11, 12);
            x = quarter_round(x, 2, 7, 8, 13);
            x = quarter_round(x, 3, 4, 9, 14);
        end
        for (int k = 0; k < 8; k++) begin
            ks[k] = {x[2 * k + 1] + init[2 * k + 1], x[2 * k] + init[2 * k]};
        end
        return ks;
    endfunction

    function automatic logic [63:0] pick_cfg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // driver: one beat per pending counter, with a random gap (none in calm stretches) after each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_wait_left  = 0;
        end else begin
            if (s_valid && s_ready) begin
                ks_expected.push_back(predict_keystream(s_block_counter));
                if (s_calm_left == 0) begin
                    s_calm      = ($urandom_range(0, 2) == 0);
                    s_calm_left = $urandom_range(10, 60);
                end
                s_calm_left--;
                s_wait_left = s_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!s_valid || s_ready) begin
                if (s_wait_left == 0 && counter_pending.size() != 0) begin
                    s_valid         <= 1'b1;
                    s_block_counter <= counter_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                    if (s_wait_left > 0) s_wait_left--;
                end
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            m_wait_left  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (ks_expected.size() == 0) begin
                    if (fail_cnt < MAX_REPORTS) $display("unexpected result beat at %0t", $time);
                    fail_cnt++;
                end else begin
                    ks_want = ks_expected.pop_front();
                    ks_got  = {m_keystream_7, m_keystream_6, m_keystream_5, m_keystream_4,
                               m_keystream_3, m_keystream_2, m_keystream_1, m_keystream_0};
                    for (int k = 0; k < 8; k++) begin
                        if (ks_got[k] !== ks_want[k]) begin
                            if (fail_cnt < MAX_REPORTS) begin
                                $display("keystream_%0d mismatch at %0t: exp %h got %h",
                                         k, $time, ks_want[k], ks_got[k]);
                            end
                            fail_cnt++;
                        end
                    end
                end
                if (m_calm_left == 0) begin
                    m_calm      = ($urandom_range(0, 2) == 0);
                    m_calm_left = $urandom_range(10, 60);
                end
                m_calm_left--;
                m_wait_left = m_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (m_wait_left > 0) begin
                m_ready <= 1'b0;
                m_wait_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("chacha20_block_keystream_top regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [ccb_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ccb_pkg::REG_KEY_PART0:  key_q[0]   = val;
            ccb_pkg::REG_KEY_PART1:  key_q[1]   = val;
            ccb_pkg::REG_KEY_PART2:  key_q[2]   = val;
            ccb_pkg::REG_KEY_PART3:  key_q[3]   = val;
            ccb_pkg::REG_NONCE_LOW:  nonce_lo_q = val;
            ccb_pkg::REG_NONCE_HIGH: nonce_hi_q = val[31:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (counter_pending.size() != 0 || s_valid || ks_expected.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic queue_counter(input logic [31:0] ctr);
        counter_pending.push_back(ctr);
    endtask

    initial begin
        logic [31:0] run_ctr;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // registers at reset value: all-zero key and nonce
        @(negedge aclk);
        queue_counter(32'h0000_0000);
        queue_counter(32'h0000_0001);
        queue_counter(32'hFFFF_FFFF);
        queue_counter(32'h8000_0000);
        queue_counter(32'h7FFF_FFFF);
        wait_idle();

        // published test vector key and nonce
        write_reg(ccb_pkg::REG_KEY_PART0,  64'h0706_0504_0302_0100);
        write_reg(ccb_pkg::REG_KEY_PART1,  64'h0F0E_0D0C_0B0A_0908);
        write_reg(ccb_pkg::REG_KEY_PART2,  64'h1716_1514_1312_1110);
        write_reg(ccb_pkg::REG_KEY_PART3,  64'h1F1E_1D1C_1B1A_1918);
        write_reg(ccb_pkg::REG_NONCE_LOW,  64'h4A00_0000_0900_0000);
        write_reg(ccb_pkg::REG_NONCE_HIGH, 64'h0);
        @(negedge aclk);
        queue_counter(32'h0000_0001);
        queue_counter(32'h0000_0002);
        wait_idle();

        // all ones; upper half of the short register must be dropped,
        // writes to unused indexes must leave everything alone
        write_reg(ccb_pkg::REG_KEY_PART0,  '1);
        write_reg(ccb_pkg::REG_KEY_PART1,  '1);
        write_reg(ccb_pkg::REG_KEY_PART2,  '1);
        write_reg(ccb_pkg::REG_KEY_PART3,  '1);
        write_reg(ccb_pkg::REG_NONCE_LOW,  '1);
        write_reg(ccb_pkg::REG_NONCE_HIGH, '1);
        write_reg(REG_SPARE6, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_SPARE7, '0);
        @(negedge aclk);
        queue_counter(32'h0000_0000);
        queue_counter(32'hFFFF_FFFF);
        queue_counter(32'h5555_5555);
        queue_counter(32'hAAAA_AAAA);
        queue_counter(32'hFFFF_FFFE);
        queue_counter(32'h0000_FFFF);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(ccb_pkg::REG_KEY_PART0,  pick_cfg_value());
            write_reg(ccb_pkg::REG_KEY_PART1,  pick_cfg_value());
            write_reg(ccb_pkg::REG_KEY_PART2,  pick_cfg_value());
            write_reg(ccb_pkg::REG_KEY_PART3,  pick_cfg_value());
            write_reg(ccb_pkg::REG_NONCE_LOW,  pick_cfg_value());
            write_reg(ccb_pkg::REG_NONCE_HIGH, pick_cfg_value());
            write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, {$urandom, $urandom});
            @(negedge aclk);
            run_ctr = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1:    queue_counter($urandom);
                    2:       queue_counter($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
                    3: begin
                        run_ctr = 32'hFFFF_FFF0 + $urandom_range(0, 15);
                        queue_counter(run_ctr);
                    end
                    default: begin
                        run_ctr = run_ctr + 1;
                        queue_counter(run_ctr);
                    end
                endcase
            end
            wait_idle();
        end

        repeat (LATENCY + 20) @(negedge aclk);
        if (ks_expected.size() != 0) begin
            if (fail_cnt < MAX_REPORTS) begin
                $display("%0d expected beats never arrived", ks_expected.size());
            end
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("chacha20_block_keystream_top regression: pass");
        end else begin
            $display("chacha20_block_keystream_top regression: fail");
        end
        $finish;
    end

endmodule
